// ===== hdl/sfla_pkg.sv =====
// Shared types, codes and helpers for the segregated free-list allocator.
// No dependencies; imported by the allocator top level.
package sfla_pkg;

    localparam int unsigned MAX_BLOCKS_DEF  = 1024;
    localparam int unsigned MAX_CLASSES_DEF = 8;
    localparam int unsigned MIN_BLOCK_DEF   = 8;

    localparam int unsigned TOT_W  = 20;
    localparam int unsigned SIZE_W = 11;
    localparam int unsigned CLS_W  = 5;
    localparam int unsigned USED_W = 18;

    localparam logic [TOT_W-1:0]  TOTAL_MAX    = '1;
    localparam logic [SIZE_W-1:0] SIZE_MAX_BLK = '1;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_OOM     = 3'd1;
    localparam logic [2:0] ST_BADFREE = 3'd2;
    localparam logic [2:0] ST_FULL    = 3'd3;
    localparam logic [2:0] ST_ZERO    = 3'd4;

    localparam logic [1:0] REQ_INIT  = 2'd0;
    localparam logic [1:0] REQ_ALLOC = 2'd1;
    localparam logic [1:0] REQ_FREE  = 2'd2;

    localparam logic [1:0] REG_START = 2'd0;
    localparam logic [1:0] REG_NCLS  = 2'd1;
    localparam logic [1:0] REG_BPC   = 2'd2;

    typedef struct packed {
        logic              valid;
        logic [31:0]       addr;
        logic [SIZE_W-1:0] size;
    } t_entry;

    function automatic logic [TOT_W-1:0] sat_add(input logic [TOT_W-1:0] a,
                                                  input logic [SIZE_W-1:0] b);
        logic [TOT_W:0] s;
        s = {1'b0, a} + {{(TOT_W+1-SIZE_W){1'b0}}, b};
        return s[TOT_W] ? TOTAL_MAX : s[TOT_W-1:0];
    endfunction

    function automatic logic [TOT_W-1:0] sat_sub(input logic [TOT_W-1:0] a,
                                                  input logic [SIZE_W-1:0] b);
        logic [TOT_W-1:0] bw;
        bw = {{(TOT_W-SIZE_W){1'b0}}, b};
        return (bw > a) ? '0 : a - bw;
    endfunction

endpackage

// ===== hdl/segregated_free_list_allocator.sv =====
// Segregated free-list allocator: free and allocated block tables in two memories.
// Depends on sfla_pkg.
//
//  channel  direction  handshake                 payload
//  request  in         i_in_valid / o_in_stall   i_req_type, i_req_size, i_req_address
//  result   out        o_out_valid / i_out_stall o_status .. o_allocated_bytes
//  config   in         psel/penable/pwrite/pready paddr, pwdata, prdata
//
// Alloc and free scan both tables in one pass, one entry a cycle.
// Init sweeps every slot once, holding the slot index at each class change.
// Zero-size allocates and unknown requests go straight to the result without a scan.
// After reset a clearing pass runs before the first request is taken.
// One request at a time; a held result stalls completion of the next one.
module segregated_free_list_allocator
    import sfla_pkg::*;
#(
    parameter int unsigned MAX_BLOCKS  = MAX_BLOCKS_DEF,
    parameter int unsigned MAX_CLASSES = MAX_CLASSES_DEF,
    parameter int unsigned MIN_BLOCK   = MIN_BLOCK_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_req_type,
    input  logic [15:0] i_req_size,
    input  logic [31:0] i_req_address,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_status,
    output logic [31:0] o_block_address,
    output logic [10:0] o_block_size,
    output logic        o_was_split,
    output logic [19:0] o_free_bytes,
    output logic [19:0] o_allocated_bytes,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int unsigned IW = $clog2(MAX_BLOCKS);
    localparam logic [IW-1:0] LAST_IDX = IW'(MAX_BLOCKS - 1);
    localparam logic [CLS_W-1:0] MAX_CLS = CLS_W'(MAX_CLASSES);

    typedef enum logic [2:0] {
        S_CLEAR, S_CLEND, S_IDLE, S_SCAN, S_LAST, S_DECIDE, S_DONE
    } t_state;

    t_state r_state;

    logic [31:0] r_start;
    logic [3:0]  r_ncls;
    logic [16:0] r_bpc;

    t_entry free_mem  [MAX_BLOCKS];
    t_entry alloc_mem [MAX_BLOCKS];
    t_entry r_frd, r_ard;

    logic          fwe, awe;
    logic [IW-1:0] fwa, awa;
    t_entry        fwd, awd;

    logic [IW-1:0] r_idx, r_rd_idx;
    logic          r_rd_vld;
    logic          r_is_init;
    logic [1:0]    r_type;
    logic [15:0]   r_size;
    logic [31:0]   r_addr;

    logic [CLS_W-1:0]  r_cls;
    logic [USED_W-1:0] r_used;
    logic [31:0]       r_gaddr;

    logic [TOT_W-1:0] r_ftot, r_atot;

    logic              r_bst_vld, r_bst_exact;
    logic [SIZE_W-1:0] r_bst_size;
    logic [31:0]       r_bst_addr;
    logic [IW-1:0]     r_bst_idx;
    logic              r_slot_vld;
    logic [IW-1:0]     r_slot_idx;

    logic [2:0]        r_res_status;
    logic [31:0]       r_res_addr;
    logic [SIZE_W-1:0] r_res_size;
    logic              r_res_split;

    logic              r_out_valid;
    logic [2:0]        r_o_status;
    logic [31:0]       r_o_addr;
    logic [SIZE_W-1:0] r_o_size;
    logic              r_o_split;
    logic [TOT_W-1:0]  r_o_ftot, r_o_atot;

    logic              cfg_we;
    logic [CLS_W-1:0]  cls_eff;
    logic              cls_active;
    logic [31:0]       cur_size;
    logic              oversize, fits, gen_blk, gen_adv;
    logic [SIZE_W-1:0] gsize;
    logic              in_acc;
    logic              e_ok, e_exact, e_take;
    logic [SIZE_W-1:0] req11;

    assign pready = 1'b1;
    assign cfg_we = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= '0;
            r_ncls  <= 4'd8;
            r_bpc   <= 17'd4096;
        end else if (cfg_we) begin
            case (paddr[3:2])
                REG_START: r_start <= pwdata;
                REG_NCLS:  r_ncls  <= pwdata[3:0];
                REG_BPC:   r_bpc   <= pwdata[16:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_START: prdata = r_start;
            REG_NCLS:  prdata = {28'd0, r_ncls};
            REG_BPC:   prdata = {15'd0, r_bpc};
            default:   prdata = '0;
        endcase
    end

    // layout generator
    always_comb begin
        if (!r_is_init)
            cls_eff = '0;
        else if ({1'b0, r_ncls} > MAX_CLS)
            cls_eff = MAX_CLS;
        else
            cls_eff = {1'b0, r_ncls};
        cls_active = r_cls < cls_eff;
        cur_size   = 32'(MIN_BLOCK) << r_cls;
        oversize   = cur_size > {21'd0, SIZE_MAX_BLK};
        gsize      = cur_size[SIZE_W-1:0];
        fits       = (r_used + {{(USED_W-SIZE_W){1'b0}}, gsize}) <= {1'b0, r_bpc};
        gen_blk    = cls_active & !oversize & fits;
        gen_adv    = cls_active & !gen_blk;
    end

    assign req11 = r_size[SIZE_W-1:0];

    // candidate evaluation for the entry read last cycle
    always_comb begin
        e_ok    = r_frd.valid && ({5'd0, r_frd.size} >= r_size);
        e_exact = {5'd0, r_frd.size} == r_size;
        if (!r_bst_vld)
            e_take = 1'b1;
        else if (e_exact && !r_bst_exact)
            e_take = 1'b1;
        else if (e_exact == r_bst_exact)
            e_take = (r_frd.size < r_bst_size) ||
                     (r_frd.size == r_bst_size && r_frd.addr < r_bst_addr);
        else
            e_take = 1'b0;
    end

    // memory write ports
    always_comb begin
        fwe = 1'b0;
        awe = 1'b0;
        fwa = r_idx;
        awa = r_idx;
        fwd = '0;
        awd = '0;
        if (r_state == S_CLEAR) begin
            awe = 1'b1;
            fwe = !gen_adv;
            if (gen_blk)
                fwd = '{valid: 1'b1, addr: r_gaddr, size: gsize};
        end else if (r_state == S_DECIDE) begin
            if (r_type == REQ_ALLOC && r_bst_vld && r_slot_vld) begin
                awe = 1'b1;
                awa = r_slot_idx;
                awd = '{valid: 1'b1, addr: r_bst_addr, size: req11};
                fwe = 1'b1;
                fwa = r_bst_idx;
                if (!r_bst_exact)
                    fwd = '{valid: 1'b1, addr: r_bst_addr + {16'd0, r_size},
                            size: r_bst_size - req11};
            end else if (r_type == REQ_FREE && r_bst_vld && r_slot_vld) begin
                awe = 1'b1;
                awa = r_bst_idx;
                fwe = 1'b1;
                fwa = r_slot_idx;
                fwd = '{valid: 1'b1, addr: r_addr, size: r_bst_size};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fwe)
            free_mem[fwa] <= fwd;
        r_frd <= free_mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (awe)
            alloc_mem[awa] <= awd;
        r_ard <= alloc_mem[r_idx];
    end

    assign in_acc     = i_in_valid && r_state == S_IDLE;
    assign o_in_stall = r_state != S_IDLE;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_is_init   <= 1'b0;
            r_idx       <= '0;
            r_cls       <= '0;
            r_used      <= '0;
            r_ftot      <= '0;
            r_atot      <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall && r_state != S_DONE)
                r_out_valid <= 1'b0;

            if (r_rd_vld) begin
                if (r_type == REQ_ALLOC) begin
                    if (e_ok && e_take) begin
                        r_bst_vld   <= 1'b1;
                        r_bst_exact <= e_exact;
                        r_bst_size  <= r_frd.size;
                        r_bst_addr  <= r_frd.addr;
                        r_bst_idx   <= r_rd_idx;
                    end
                    if (!r_ard.valid && !r_slot_vld) begin
                        r_slot_vld <= 1'b1;
                        r_slot_idx <= r_rd_idx;
                    end
                end else begin
                    if (r_ard.valid && r_ard.addr == r_addr && !r_bst_vld) begin
                        r_bst_vld  <= 1'b1;
                        r_bst_size <= r_ard.size;
                        r_bst_idx  <= r_rd_idx;
                    end
                    if (!r_frd.valid && !r_slot_vld) begin
                        r_slot_vld <= 1'b1;
                        r_slot_idx <= r_rd_idx;
                    end
                end
            end

            unique case (r_state)
                S_CLEAR: begin
                    if (gen_adv) begin
                        r_cls  <= r_cls + 1'b1;
                        r_used <= '0;
                    end else begin
                        if (gen_blk) begin
                            r_gaddr <= r_gaddr + {21'd0, gsize};
                            r_used  <= r_used + {{(USED_W-SIZE_W){1'b0}}, gsize};
                            r_ftot  <= sat_add(r_ftot, gsize);
                        end
                        if (r_idx == LAST_IDX)
                            r_state <= S_CLEND;
                        else
                            r_idx <= r_idx + 1'b1;
                    end
                end
                S_CLEND: begin
                    if (!cls_active || gen_blk) begin
                        r_res_status <= cls_active ? ST_FULL : ST_OK;
                        r_res_addr   <= '0;
                        r_res_size   <= '0;
                        r_res_split  <= 1'b0;
                        r_state      <= r_is_init ? S_DONE : S_IDLE;
                    end else begin
                        r_cls  <= r_cls + 1'b1;
                        r_used <= '0;
                    end
                end
                S_IDLE: begin
                    if (in_acc) begin
                        r_type       <= i_req_type;
                        r_size       <= i_req_size;
                        r_addr       <= i_req_address;
                        r_idx        <= '0;
                        r_bst_vld    <= 1'b0;
                        r_bst_exact  <= 1'b0;
                        r_slot_vld   <= 1'b0;
                        r_res_status <= ST_OK;
                        r_res_addr   <= '0;
                        r_res_size   <= '0;
                        r_res_split  <= 1'b0;
                        case (i_req_type)
                            REQ_INIT: begin
                                r_is_init <= 1'b1;
                                r_cls     <= '0;
                                r_used    <= '0;
                                r_gaddr   <= r_start;
                                r_ftot    <= '0;
                                r_atot    <= '0;
                                r_state   <= S_CLEAR;
                            end
                            REQ_ALLOC: begin
                                if (i_req_size == '0) begin
                                    r_res_status <= ST_ZERO;
                                    r_state      <= S_DONE;
                                end else begin
                                    r_state <= S_SCAN;
                                end
                            end
                            REQ_FREE: r_state <= S_SCAN;
                            default:  r_state <= S_DONE;
                        endcase
                    end
                end
                S_SCAN: begin
                    r_rd_vld <= 1'b1;
                    r_rd_idx <= r_idx;
                    if (r_idx == LAST_IDX)
                        r_state <= S_LAST;
                    else
                        r_idx <= r_idx + 1'b1;
                end
                S_LAST: begin
                    r_rd_vld <= 1'b0;
                    r_state  <= S_DECIDE;
                end
                S_DECIDE: begin
                    if (!r_bst_vld) begin
                        r_res_status <= (r_type == REQ_ALLOC) ? ST_OOM : ST_BADFREE;
                    end else if (!r_slot_vld) begin
                        r_res_status <= ST_FULL;
                    end else if (r_type == REQ_ALLOC) begin
                        r_res_addr  <= r_bst_addr;
                        r_res_size  <= req11;
                        r_res_split <= !r_bst_exact;
                        r_ftot      <= sat_sub(r_ftot, req11);
                        r_atot      <= sat_add(r_atot, req11);
                    end else begin
                        r_res_addr <= r_addr;
                        r_res_size <= r_bst_size;
                        r_ftot     <= sat_add(r_ftot, r_bst_size);
                        r_atot     <= sat_sub(r_atot, r_bst_size);
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid <= 1'b1;
                        r_o_status  <= r_res_status;
                        r_o_addr    <= r_res_addr;
                        r_o_size    <= r_res_size;
                        r_o_split   <= r_res_split;
                        r_o_ftot    <= r_ftot;
                        r_o_atot    <= r_atot;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_status          = r_o_status;
    assign o_block_address   = r_o_addr;
    assign o_block_size      = r_o_size;
    assign o_was_split       = r_o_split;
    assign o_free_bytes      = r_o_ftot;
    assign o_allocated_bytes = r_o_atot;

endmodule
